FILE: hdl/assert_macros.svh
// assertion macros for the scheduler top level
// no dependencies; included by the top module, which carries concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tpq_pkg.sv
// shared constants, action codes and command type of the job scheduler
// no dependencies; imported by the scheduler modules and interfaces other than tpq_ram
`default_nettype none

package tpq_pkg;

  // ring geometry and field widths
  localparam int QUEUE_DEPTH  = 8;
  localparam int TAG_BITS     = 16;
  localparam int PTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_BITS    = 32;
  localparam int ENTRY_BITS   = TAG_BITS + TIME_BITS;

  // statistics formats
  localparam int AVG_BITS     = 40;
  localparam int AVG_FRAC     = 8;
  localparam int AVG_OUT_BITS = 16;
  localparam int PCT_BITS     = 7;
  localparam int PCT_MAX      = 100;
  localparam int PEND_BITS    = 5;
  localparam int PROD_BITS    = 39;

  // average update divides by ten, a byte of dividend per round
  localparam int AVG_DIV      = 10;
  localparam int DIV10_BITS   = 48;
  localparam int DIV10_STEP   = 8;
  localparam int DIV10_ROUNDS = DIV10_BITS / DIV10_STEP;
  localparam int RND_BITS     = $clog2(DIV10_ROUNDS);

  // action codes
  localparam logic [1:0] ACT_ENQUEUE  = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_FINISH   = 2'd2;
  localparam logic [1:0] ACT_STATS    = 2'd3;

  typedef struct packed {
    logic [1:0]           action;
    logic                 high_priority;
    logic [TAG_BITS-1:0]  job_tag;
    logic [TIME_BITS-1:0] now_ms;
    logic                 gate_closed;
    logic [TIME_BITS-1:0] elapsed_ms;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/tpq_cmd_if.sv
// command channel of the job scheduler: valid/ready plus request fields
// depends on tpq_pkg
`default_nettype none

interface tpq_cmd_if;
  import tpq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic                 high_priority;
  logic [TAG_BITS-1:0]  job_tag;
  logic [TIME_BITS-1:0] now_ms;
  logic                 gate_closed;
  logic [TIME_BITS-1:0] elapsed_ms;

  modport source (
    output valid, action, high_priority, job_tag, now_ms, gate_closed, elapsed_ms,
    input  ready
  );
  modport sink (
    input  valid, action, high_priority, job_tag, now_ms, gate_closed, elapsed_ms,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/tpq_res_if.sv
// result channel of the job scheduler: valid/ready plus result fields
// depends on tpq_pkg
`default_nettype none

interface tpq_res_if;
  import tpq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    enqueue_accepted;
  logic                    job_valid;
  logic [TAG_BITS-1:0]     job_out_tag;
  logic [TIME_BITS-1:0]    job_wait_ms;
  logic [AVG_OUT_BITS-1:0] wait_average_ms;
  logic [PCT_BITS-1:0]     busy_percent;
  logic [PEND_BITS-1:0]    pending_total;
  logic                    busy_res;

  modport source (
    output valid, enqueue_accepted, job_valid, job_out_tag, job_wait_ms,
           wait_average_ms, busy_percent, pending_total, busy_res,
    input  ready
  );
  modport sink (
    input  valid, enqueue_accepted, job_valid, job_out_tag, job_wait_ms,
           wait_average_ms, busy_percent, pending_total, busy_res,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/two_priority_job_queue_with_stats.sv
// Strict-priority two-ring job scheduler with wait and busy statistics.
// Channels: cmd (sink) carries one action per beat: enqueue, dispatch,
// job finished or statistics read; res (source) returns exactly one result
// beat per command, in command order. Both use valid/ready; a beat moves
// when valid and ready are high at a rising edge of clk.
// From the back end's idle state, enqueue, job finished, dispatch with
// nothing eligible and a statistics read on an empty window load the
// result directly; a dispatched job first reads the ring, then a zero
// wait average takes the sample as is and any other runs six rounds of
// the divide-by-ten; other statistics reads wait on the one-bit-per-cycle
// percentage divider. The back end runs one command at a time and takes
// the next once the result register is free.
// A two-entry command queue in front keeps taking beats while a result waits.
// Reset (rst, synchronous) empties both rings, clears busy, the busy sum,
// the wait average and the window start; ring contents are not cleared.
// When the receiver stalls the result holds and the command queue fills.
// depends on tpq_pkg, tpq_cmd_if, tpq_res_if, tpq_front, tpq_back
`default_nettype none
`include "assert_macros.svh"

module two_priority_job_queue_with_stats (
  input  logic      clk,
  input  logic      rst,
  tpq_cmd_if.sink   cmd,
  tpq_res_if.source res
);
  import tpq_pkg::*;

  cmd_t q_cmd;
  logic q_valid;
  logic q_ready;

  // accept and queue commands
  tpq_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_cmd   (q_cmd),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  // execute commands and hold results
  tpq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_cmd),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .res       (res)
  );

  // checks
  `ASSERT_IMPLIES(a_pct_cap, clk, rst, res.valid, res.busy_percent <= PCT_BITS'(PCT_MAX), "busy percent above cap")
  `ASSERT_IMPLIES(a_job_busy, clk, rst, res.valid && res.job_valid, res.busy_res, "dispatched job not busy")
  `ASSERT_IMPLIES(a_pend_max, clk, rst, res.valid, res.pending_total <= PEND_BITS'(2 * QUEUE_DEPTH + 1), "pending count too large")
  `ASSERT_IMPLIES(a_one_kind, clk, rst, res.valid, !(res.enqueue_accepted && res.job_valid), "enqueue and dispatch in one result")
  `ASSERT_NEXT(a_queue_hold, clk, rst, q_valid && !q_ready, q_valid, "queued command dropped")

endmodule

`default_nettype wire

FILE: hdl/tpq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tpq_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/tpq_front.sv
// front end: takes command beats and holds them in a two-entry queue
// depends on tpq_pkg and tpq_cmd_if
`default_nettype none

module tpq_front (
  input  logic           clk,
  input  logic           rst,
  tpq_cmd_if.sink        cmd,
  output tpq_pkg::cmd_t  q_cmd,
  output logic           q_valid,
  input  logic           q_ready
);
  import tpq_pkg::*;

  cmd_t       ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  cmd_t       beat;

  // gather the beat fields into one command word
  always_comb begin
    beat.action        = cmd.action;
    beat.high_priority = cmd.high_priority;
    beat.job_tag       = cmd.job_tag;
    beat.now_ms        = cmd.now_ms;
    beat.gate_closed   = cmd.gate_closed;
    beat.elapsed_ms    = cmd.elapsed_ms;
  end

  assign cmd.ready = (fill != 2'd2);
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (fill != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_cmd     = ent[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= beat;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tpq_div.sv
// restoring divider, one quotient bit per cycle, for the busy percentage
// depends on tpq_pkg
`default_nettype none

module tpq_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tpq_pkg::PROD_BITS-1:0]  dividend,
  input  logic [tpq_pkg::TIME_BITS-1:0]  divisor,
  output logic                           done,
  output logic [tpq_pkg::PROD_BITS-1:0]  quotient
);
  import tpq_pkg::*;

  localparam int STEP_BITS = $clog2(PROD_BITS);

  logic                 running;
  logic [STEP_BITS-1:0] step;
  logic [TIME_BITS:0]   rem;
  logic [PROD_BITS-1:0] quo;
  logic [TIME_BITS-1:0] dsr;
  logic [TIME_BITS:0]   rem_sh;
  logic                 ge;

  // one trial subtraction
  assign rem_sh   = {rem[TIME_BITS-1:0], quo[PROD_BITS-1]};
  assign ge       = (rem_sh >= {1'b0, dsr});
  assign quotient = quo;

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (running) begin
      quo <= {quo[PROD_BITS-2:0], ge};
      rem <= ge ? (rem_sh - {1'b0, dsr}) : rem_sh;
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_BITS'(1);
        if (step == STEP_BITS'(PROD_BITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tpq_back.sv
// back end: rings, dispatch, wait average, busy statistics, result register
// depends on tpq_pkg, tpq_res_if, tpq_ram and tpq_div
`default_nettype none

module tpq_back (
  input  logic           clk,
  input  logic           rst,
  input  tpq_pkg::cmd_t  cmd,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  tpq_res_if.source      res
);
  import tpq_pkg::*;

  localparam int SUM_BITS = PTR_BITS + 1;
  localparam int A7_BITS  = AVG_BITS + 3;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_AVG   = 3'd2;
  localparam logic [2:0] S_DIV10 = 3'd3;
  localparam logic [2:0] S_PCT   = 3'd4;

  // control state
  logic [2:0]           state, state_next;
  logic [PTR_BITS-1:0]  hi_head, hi_head_next, lo_head, lo_head_next;
  logic [CNT_BITS-1:0]  hi_count, hi_count_next, lo_count, lo_count_next;
  logic                 busy, busy_next;
  logic [TIME_BITS-1:0] busy_sum, busy_sum_next;
  logic [AVG_BITS-1:0]  avg, avg_next;
  logic [TIME_BITS-1:0] window_start, window_start_next;
  logic [RND_BITS-1:0]  rnd, rnd_next;
  logic                 out_valid, out_valid_next;

  // working registers
  cmd_t                 cur, cur_next;
  logic                 from_high, from_high_next;
  logic [TIME_BITS-1:0] wait_ms, wait_next;
  logic [TAG_BITS-1:0]  tag_q, tag_next;
  logic [A7_BITS-1:0]   avg7, avg7_next;
  logic [DIV10_BITS-1:0] dv, dv_next;
  logic [3:0]           rem10, rem10_next;

  // result register
  logic                    o_acc, o_jv, o_busy;
  logic [TAG_BITS-1:0]     o_tag;
  logic [TIME_BITS-1:0]    o_wait;
  logic [AVG_OUT_BITS-1:0] o_avg;
  logic [PCT_BITS-1:0]     o_pct;
  logic [PEND_BITS-1:0]    o_pend;

  // result load
  logic                 load;
  logic                 l_acc, l_jv;
  logic [TAG_BITS-1:0]  l_tag;
  logic [TIME_BITS-1:0] l_wait;
  logic [PCT_BITS-1:0]  l_pct;

  // ring ports
  logic                  hi_we, lo_we;
  logic [PTR_BITS-1:0]   hi_tail, lo_tail;
  logic [SUM_BITS-1:0]   hi_tsum, lo_tsum;
  logic [ENTRY_BITS-1:0] wdata, hi_rd, lo_rd, rd;

  // misc
  logic                  take;
  logic [TIME_BITS:0]    sum33;
  logic [TIME_BITS-1:0]  win;
  logic                  div_start, div_done;
  logic [PROD_BITS-1:0]  div_quo, prod;
  logic [DIV10_STEP+3:0] d10;

  // one round of division by ten over a byte of dividend
  function automatic logic [DIV10_STEP+3:0] div10_round(
    input logic [3:0]            rem_in,
    input logic [DIV10_STEP-1:0] bits
  );
    logic [4:0]            r;
    logic [DIV10_STEP-1:0] q;
    r = {1'b0, rem_in};
    q = '0;
    for (int i = DIV10_STEP - 1; i >= 0; i--) begin
      r    = {r[3:0], bits[i]};
      q[i] = (r >= 5'(AVG_DIV));
      if (q[i]) begin
        r = r - 5'(AVG_DIV);
      end
    end
    return {q, r[3:0]};
  endfunction

  // ring write slots, head plus count wrapped at the depth
  always_comb begin
    hi_tsum = {1'b0, hi_head} + SUM_BITS'(hi_count);
    lo_tsum = {1'b0, lo_head} + SUM_BITS'(lo_count);
    if (hi_tsum >= SUM_BITS'(QUEUE_DEPTH)) begin
      hi_tsum = hi_tsum - SUM_BITS'(QUEUE_DEPTH);
    end
    if (lo_tsum >= SUM_BITS'(QUEUE_DEPTH)) begin
      lo_tsum = lo_tsum - SUM_BITS'(QUEUE_DEPTH);
    end
    hi_tail = hi_tsum[PTR_BITS-1:0];
    lo_tail = lo_tsum[PTR_BITS-1:0];
  end

  assign wdata = {cmd.job_tag, cmd.now_ms};

  tpq_ram #(.WIDTH(ENTRY_BITS), .DEPTH(QUEUE_DEPTH)) u_hi_ring (
    .clk   (clk),
    .we    (hi_we),
    .waddr (hi_tail),
    .wdata (wdata),
    .raddr (hi_head),
    .rdata (hi_rd)
  );

  tpq_ram #(.WIDTH(ENTRY_BITS), .DEPTH(QUEUE_DEPTH)) u_lo_ring (
    .clk   (clk),
    .we    (lo_we),
    .waddr (lo_tail),
    .wdata (wdata),
    .raddr (lo_head),
    .rdata (lo_rd)
  );

  // 100 times the busy sum as shifts and adds
  assign prod = (PROD_BITS'(busy_sum) << 6) + (PROD_BITS'(busy_sum) << 5)
              + (PROD_BITS'(busy_sum) << 2);

  tpq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (win),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign take      = (state == S_IDLE) && cmd_valid && !out_valid;
  assign cmd_ready = (state == S_IDLE) && !out_valid;
  assign win       = cmd.now_ms - window_start;
  assign sum33     = {1'b0, busy_sum} + {1'b0, cmd.elapsed_ms};
  assign rd        = from_high ? hi_rd : lo_rd;
  assign d10       = div10_round(rem10, dv[DIV10_BITS-1 -: DIV10_STEP]);

  // sequencer
  always_comb begin
    state_next        = state;
    hi_head_next      = hi_head;
    lo_head_next      = lo_head;
    hi_count_next     = hi_count;
    lo_count_next     = lo_count;
    busy_next         = busy;
    busy_sum_next     = busy_sum;
    avg_next          = avg;
    window_start_next = window_start;
    rnd_next          = rnd;
    cur_next          = cur;
    from_high_next    = from_high;
    wait_next         = wait_ms;
    tag_next          = tag_q;
    avg7_next         = avg7;
    dv_next           = dv;
    rem10_next        = rem10;
    hi_we             = 1'b0;
    lo_we             = 1'b0;
    div_start         = 1'b0;
    load              = 1'b0;
    l_acc             = 1'b0;
    l_jv              = 1'b0;
    l_tag             = '0;
    l_wait            = '0;
    l_pct             = '0;

    case (state)
      S_IDLE: begin
        if (take) begin
          cur_next = cmd;
          case (cmd.action)
            ACT_ENQUEUE: begin
              load = 1'b1;
              if (cmd.high_priority) begin
                if (hi_count < CNT_BITS'(QUEUE_DEPTH)) begin
                  hi_we         = 1'b1;
                  hi_count_next = hi_count + CNT_BITS'(1);
                  l_acc         = 1'b1;
                end
              end else begin
                if (lo_count < CNT_BITS'(QUEUE_DEPTH)) begin
                  lo_we         = 1'b1;
                  lo_count_next = lo_count + CNT_BITS'(1);
                  l_acc         = 1'b1;
                end
              end
            end
            ACT_DISPATCH: begin
              if (!busy && hi_count != '0) begin
                from_high_next = 1'b1;
                hi_count_next  = hi_count - CNT_BITS'(1);
                hi_head_next   = (hi_head == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                               : hi_head + PTR_BITS'(1);
                busy_next      = 1'b1;
                state_next     = S_READ;
              end else if (!busy && !cmd.gate_closed && lo_count != '0) begin
                from_high_next = 1'b0;
                lo_count_next  = lo_count - CNT_BITS'(1);
                lo_head_next   = (lo_head == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                               : lo_head + PTR_BITS'(1);
                busy_next      = 1'b1;
                state_next     = S_READ;
              end else begin
                load = 1'b1;
              end
            end
            ACT_FINISH: begin
              load = 1'b1;
              if (busy) begin
                busy_sum_next = sum33[TIME_BITS] ? '1 : sum33[TIME_BITS-1:0];
                busy_next     = 1'b0;
              end
            end
            ACT_STATS: begin
              busy_sum_next     = '0;
              window_start_next = cmd.now_ms;
              if (win != '0) begin
                div_start  = 1'b1;
                state_next = S_PCT;
              end else begin
                load = 1'b1;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end

      // ring entry arrives: wait time and 7 times the old average
      S_READ: begin
        wait_next  = cur.now_ms - rd[TIME_BITS-1:0];
        tag_next   = rd[ENTRY_BITS-1:TIME_BITS];
        avg7_next  = (A7_BITS'(avg) << 3) - A7_BITS'(avg);
        state_next = S_AVG;
      end

      // a zero average takes the sample as is, else start the divide by ten
      S_AVG: begin
        if (avg == '0) begin
          avg_next   = AVG_BITS'(wait_ms) << AVG_FRAC;
          load       = 1'b1;
          l_jv       = 1'b1;
          l_tag      = tag_q;
          l_wait     = wait_ms;
          state_next = S_IDLE;
        end else begin
          dv_next    = DIV10_BITS'(avg7)
                     + (DIV10_BITS'(wait_ms) << (AVG_FRAC + 1))
                     + (DIV10_BITS'(wait_ms) << AVG_FRAC);
          rem10_next = '0;
          rnd_next   = '0;
          state_next = S_DIV10;
        end
      end

      S_DIV10: begin
        dv_next    = {dv[DIV10_BITS-DIV10_STEP-1:0], d10[DIV10_STEP+3:4]};
        rem10_next = d10[3:0];
        rnd_next   = rnd + RND_BITS'(1);
        if (rnd == RND_BITS'(DIV10_ROUNDS - 1)) begin
          avg_next   = dv_next[AVG_BITS-1:0];
          load       = 1'b1;
          l_jv       = 1'b1;
          l_tag      = tag_q;
          l_wait     = wait_ms;
          state_next = S_IDLE;
        end
      end

      S_PCT: begin
        if (div_done) begin
          load       = 1'b1;
          l_pct      = (div_quo > PROD_BITS'(PCT_MAX)) ? PCT_BITS'(PCT_MAX)
                     : div_quo[PCT_BITS-1:0];
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // result register handshake
    out_valid_next = out_valid;
    if (out_valid && res.ready) begin
      out_valid_next = 1'b0;
    end
    if (load) begin
      out_valid_next = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      hi_head      <= '0;
      lo_head      <= '0;
      hi_count     <= '0;
      lo_count     <= '0;
      busy         <= 1'b0;
      busy_sum     <= '0;
      avg          <= '0;
      window_start <= '0;
      rnd          <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      hi_head      <= hi_head_next;
      lo_head      <= lo_head_next;
      hi_count     <= hi_count_next;
      lo_count     <= lo_count_next;
      busy         <= busy_next;
      busy_sum     <= busy_sum_next;
      avg          <= avg_next;
      window_start <= window_start_next;
      rnd          <= rnd_next;
      out_valid    <= out_valid_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cur       <= cur_next;
    from_high <= from_high_next;
    wait_ms   <= wait_next;
    tag_q     <= tag_next;
    avg7      <= avg7_next;
    dv        <= dv_next;
    rem10     <= rem10_next;
  end

  // result payload, status fields taken from the state after the step
  always_ff @(posedge clk) begin
    if (load) begin
      o_acc  <= l_acc;
      o_jv   <= l_jv;
      o_tag  <= l_tag;
      o_wait <= l_wait;
      o_pct  <= l_pct;
      o_avg  <= (avg_next[AVG_BITS-1:AVG_FRAC+AVG_OUT_BITS] != '0) ? '1
              : avg_next[AVG_FRAC +: AVG_OUT_BITS];
      o_pend <= PEND_BITS'(hi_count_next) + PEND_BITS'(lo_count_next)
              + PEND_BITS'(busy_next);
      o_busy <= busy_next;
    end
  end

  assign res.valid            = out_valid;
  assign res.enqueue_accepted = o_acc;
  assign res.job_valid        = o_jv;
  assign res.job_out_tag      = o_tag;
  assign res.job_wait_ms      = o_wait;
  assign res.wait_average_ms  = o_avg;
  assign res.busy_percent     = o_pct;
  assign res.pending_total    = o_pend;
  assign res.busy_res         = o_busy;

endmodule

`default_nettype wire
